// ===== design/rrts_pkg.sv =====
// ---------------------------------------------------------------------------
// rrts_pkg: shared types and codes for the round-robin task scheduler
// Operation, status and task-state codes plus the sequencer state type.
// ---------------------------------------------------------------------------
package rrts_pkg;

  // Operation codes carried by a request
  typedef enum logic [2:0] {
    FN_INIT    = 3'd0,
    FN_CREATE  = 3'd1,
    FN_YIELD   = 3'd2,
    FN_EXIT    = 3'd3,
    FN_START   = 3'd4,
    FN_RECLAIM = 3'd5,
    FN_QUERY   = 3'd6
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_REFUSED = 2'd1,
    STS_NOCHG   = 2'd2,
    STS_HALT    = 2'd3
  } status_e;

  // Per-slot task state
  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_ZOMBIE  = 2'd2,
    TS_EXITED  = 2'd3
  } tstate_e;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SETUP,
    SQ_WALK,
    SQ_QUERY,
    SQ_RESP
  } seq_state_e;

endpackage

// ===== design/round_robin_task_scheduler.sv =====
// ---------------------------------------------------------------------------
// round_robin_task_scheduler: task-state table with a round-robin picker
// One request per operation (init, create, yield, exit, start, reclaim,
// query); one result per request.
// ---------------------------------------------------------------------------
// Usage:
//  - Request channel: in_valid_i / in_stall_o with func_i and task_index_i.
//    A request is taken at a rising edge with in_valid_i high and in_stall_o
//    low. in_stall_o stays high while a request is being worked on.
//  - Result channel: out_valid_o / out_stall_i with the result fields. The
//    result sits in an output register, so the next request is taken while
//    a finished result still waits for the receiver.
//  - Init, create and refused requests go from setup straight to the
//    response state; a query reads the memory in a query state between them.
//    Yield, exit, start and reclaim walk the task table through one shared
//    wrap-around incrementer and the single read port of the state memory,
//    one slot per cycle. The walk stops early at the first ready slot for
//    yield, exit and start.
//  - The input reopens once the result is loaded into the output register,
//    so a new request is taken only after the previous one has finished.
//  - Reset: the table holds only the idle task in slot zero, ready, and no
//    task runs. Other slots read undefined until a create writes them.
//  - A stalled receiver holds the result; a finished request then waits in
//    the response state until the output register frees.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [3:0] task_index_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [3:0] chosen_task_o,
  output logic [3:0] previous_task_o,
  output logic       switched_o,
  output logic       running_valid_o,
  output logic [3:0] running_task_o,
  output logic [4:0] tasks_in_table_o,
  output logic [1:0] queried_state_o,
  output logic       query_valid_o,
  output logic [4:0] reclaimed_count_o
);

  localparam int IDX_W = $clog2(MAX_TASKS);      // slot index
  localparam int CNT_W = $clog2(MAX_TASKS + 1);  // slot count, 0..MAX_TASKS

  // ---- sequencer and scheduler state ----
  seq_state_e       state_q, state_d;
  logic [2:0]       func_q, func_d;
  logic [3:0]       qidx_q, qidx_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             cur_valid_q, cur_valid_d;
  logic [IDX_W-1:0] cur_q, cur_d;

  // ---- table walk ----
  logic [IDX_W-1:0] walk_addr_q, walk_addr_d;
  logic [CNT_W-1:0] walk_left_q, walk_left_d;  // reads still to issue
  logic             chk_v_q, chk_v_d;          // read data in flight
  logic [IDX_W-1:0] chk_addr_q, chk_addr_d;    // slot of that read data

  // ---- result being built ----
  status_e          res_status_q, res_status_d;
  logic [3:0]       res_chosen_q, res_chosen_d;
  logic [3:0]       res_prev_q, res_prev_d;
  logic             res_sw_q, res_sw_d;
  logic [1:0]       res_qstate_q, res_qstate_d;
  logic             res_qvalid_q, res_qvalid_d;
  logic [CNT_W-1:0] res_recl_q, res_recl_d;

  // ---- output register ----
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [3:0]       out_chosen_q, out_chosen_d;
  logic [3:0]       out_prev_q, out_prev_d;
  logic             out_sw_q, out_sw_d;
  logic             out_rvalid_q, out_rvalid_d;
  logic [3:0]       out_rtask_q, out_rtask_d;
  logic [4:0]       out_total_q, out_total_d;
  logic [1:0]       out_qstate_q, out_qstate_d;
  logic             out_qvalid_q, out_qvalid_d;
  logic [4:0]       out_recl_q, out_recl_d;

  // ---- task-state memory: one write and one registered read a cycle ----
  logic [1:0]       tstate_mem [MAX_TASKS];
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [1:0]       mem_wdata;
  logic [1:0]       mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tstate_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= tstate_mem[mem_raddr];
    end
  end

  // Idle task in slot zero reads ready from reset until first written
  logic             slot0_set_q;
  logic             rd_zero_q;
  logic [1:0]       rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_set_q <= 1'b0;
      rd_zero_q   <= 1'b0;
    end else begin
      if (mem_we && (mem_waddr == '0)) begin
        slot0_set_q <= 1'b1;
      end
      if (mem_re) begin
        rd_zero_q <= (mem_raddr == '0) && !slot0_set_q;
      end
    end
  end

  assign rd_data = rd_zero_q ? TS_READY : mem_rdata_q;

  // ---- shared helpers ----
  logic             cur_ok;
  logic             q_ok;
  logic             full;
  logic             two_plus;
  logic [IDX_W-1:0] inc_base;
  logic [IDX_W-1:0] inc_addr;
  logic             rd_walk;
  logic             hit;
  logic             walk_end;
  logic             is_reclaim;
  logic             can_load;

  assign cur_ok     = cur_valid_q && (CNT_W'(cur_q) < total_q);
  assign q_ok       = 7'(qidx_q) < 7'(total_q);
  assign full       = total_q >= CNT_W'(MAX_TASKS);
  assign two_plus   = total_q >= CNT_W'(2);
  assign is_reclaim = func_q == FN_RECLAIM;

  // Shared wrap-around incrementer: seeds the yield and exit walks in setup, steps the walk after
  assign inc_base = (state_q == SQ_SETUP) ? cur_q : walk_addr_q;
  assign inc_addr = ((CNT_W'(inc_base) + CNT_W'(1)) >= total_q) ? '0
                  : IDX_W'(inc_base + IDX_W'(1));

  assign rd_walk  = walk_left_q != '0;
  assign hit      = chk_v_q && (rd_data == (is_reclaim ? TS_ZOMBIE : TS_READY));
  assign walk_end = !rd_walk && !chk_v_q;
  assign can_load = !out_valid_q || !out_stall_i;

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: begin
        if (in_valid_i) state_d = SQ_SETUP;
      end
      SQ_SETUP: begin
        case (func_q)
          FN_YIELD:   state_d = (cur_ok && two_plus) ? SQ_WALK : SQ_RESP;
          FN_EXIT:    state_d = cur_ok ? SQ_WALK : SQ_RESP;
          FN_START:   state_d = two_plus ? SQ_WALK : SQ_RESP;
          FN_RECLAIM: state_d = SQ_WALK;
          FN_QUERY:   state_d = q_ok ? SQ_QUERY : SQ_RESP;
          default:    state_d = SQ_RESP;
        endcase
      end
      SQ_WALK: begin
        if ((!is_reclaim && hit) || walk_end) state_d = SQ_RESP;
      end
      SQ_QUERY: state_d = SQ_RESP;
      SQ_RESP: begin
        if (can_load) state_d = SQ_IDLE;
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // ---- datapath control ----
  always_comb begin
    func_d       = func_q;
    qidx_d       = qidx_q;
    total_d      = total_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    walk_addr_d  = walk_addr_q;
    walk_left_d  = walk_left_q;
    chk_v_d      = 1'b0;
    chk_addr_d   = chk_addr_q;
    res_status_d = res_status_q;
    res_chosen_d = res_chosen_q;
    res_prev_d   = res_prev_q;
    res_sw_d     = res_sw_q;
    res_qstate_d = res_qstate_q;
    res_qvalid_d = res_qvalid_q;
    res_recl_d   = res_recl_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_raddr    = '0;
    mem_wdata    = TS_READY;

    out_valid_d  = out_stall_i ? out_valid_q : 1'b0;
    out_status_d = out_status_q;
    out_chosen_d = out_chosen_q;
    out_prev_d   = out_prev_q;
    out_sw_d     = out_sw_q;
    out_rvalid_d = out_rvalid_q;
    out_rtask_d  = out_rtask_q;
    out_total_d  = out_total_q;
    out_qstate_d = out_qstate_q;
    out_qvalid_d = out_qvalid_q;
    out_recl_d   = out_recl_q;

    case (state_q)
      SQ_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          qidx_d = task_index_i;
        end
      end

      SQ_SETUP: begin
        res_status_d = STS_DONE;
        res_chosen_d = '0;
        res_prev_d   = '0;
        res_sw_d     = 1'b0;
        res_qstate_d = '0;
        res_qvalid_d = 1'b0;
        res_recl_d   = '0;
        walk_left_d  = '0;
        case (func_q)
          FN_INIT: begin
            total_d     = CNT_W'(1);
            cur_valid_d = 1'b0;
            cur_d       = '0;
            mem_we      = 1'b1;
            mem_waddr   = '0;
            mem_wdata   = TS_READY;
          end
          FN_CREATE: begin
            if (full) begin
              res_status_d = STS_REFUSED;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = IDX_W'(total_q);
              mem_wdata    = TS_READY;
              res_chosen_d = 4'(total_q);
              total_d      = total_q + CNT_W'(1);
            end
          end
          FN_YIELD: begin
            if (!cur_ok || !two_plus) begin
              res_status_d = STS_NOCHG;
            end else begin
              // current task goes back to ready before the search
              mem_we      = 1'b1;
              mem_waddr   = cur_q;
              mem_wdata   = TS_READY;
              res_prev_d  = 4'(cur_q);
              walk_addr_d = inc_addr;
              walk_left_d = total_q;
            end
          end
          FN_EXIT: begin
            if (!cur_ok) begin
              res_status_d = STS_HALT;
            end else begin
              mem_we      = 1'b1;
              mem_waddr   = cur_q;
              mem_wdata   = TS_ZOMBIE;
              res_prev_d  = 4'(cur_q);
              walk_addr_d = inc_addr;
              walk_left_d = total_q;
            end
          end
          FN_START: begin
            if (!two_plus) begin
              res_status_d = STS_NOCHG;
            end else begin
              // idle task in slot zero is skipped
              walk_addr_d = IDX_W'(1);
              walk_left_d = total_q - CNT_W'(1);
            end
          end
          FN_RECLAIM: begin
            walk_addr_d = '0;
            walk_left_d = total_q;
          end
          FN_QUERY: begin
            if (q_ok) begin
              mem_re    = 1'b1;
              mem_raddr = IDX_W'(qidx_q);
            end else begin
              res_status_d = STS_REFUSED;
            end
          end
          default: res_status_d = STS_REFUSED;
        endcase
      end

      SQ_WALK: begin
        // issue the next read while checking the previous one
        mem_re     = rd_walk;
        mem_raddr  = walk_addr_q;
        chk_v_d    = rd_walk;
        chk_addr_d = walk_addr_q;
        if (rd_walk) begin
          walk_addr_d = inc_addr;
          walk_left_d = walk_left_q - CNT_W'(1);
        end
        if (is_reclaim) begin
          if (hit) begin
            mem_we     = 1'b1;
            mem_waddr  = chk_addr_q;
            mem_wdata  = TS_EXITED;
            res_recl_d = res_recl_q + CNT_W'(1);
          end
        end else if (hit) begin
          chk_v_d      = 1'b0;
          mem_we       = 1'b1;
          mem_waddr    = chk_addr_q;
          mem_wdata    = TS_RUNNING;
          cur_d        = chk_addr_q;
          cur_valid_d  = 1'b1;
          res_chosen_d = 4'(chk_addr_q);
          case (func_q)
            FN_YIELD: res_sw_d = chk_addr_q != cur_q;
            FN_START: begin
              res_sw_d   = 1'b1;
              res_prev_d = cur_ok ? 4'(cur_q) : 4'd0;
            end
            default:  res_sw_d = 1'b1;
          endcase
        end else if (walk_end) begin
          case (func_q)
            FN_YIELD: begin
              // nobody else ready: keep running
              mem_we       = 1'b1;
              mem_waddr    = cur_q;
              mem_wdata    = TS_RUNNING;
              res_chosen_d = 4'(cur_q);
            end
            FN_EXIT: begin
              cur_valid_d  = 1'b0;
              res_status_d = STS_HALT;
            end
            default: res_status_d = STS_NOCHG;
          endcase
        end
      end

      SQ_QUERY: begin
        res_qstate_d = rd_data;
        res_qvalid_d = 1'b1;
      end

      SQ_RESP: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_chosen_d = res_chosen_q;
          out_prev_d   = res_prev_q;
          out_sw_d     = res_sw_q;
          out_rvalid_d = cur_valid_q;
          out_rtask_d  = cur_valid_q ? 4'(cur_q) : 4'd0;
          out_total_d  = 5'(total_q);
          out_qstate_d = res_qstate_q;
          out_qvalid_d = res_qvalid_q;
          out_recl_d   = 5'(res_recl_q);
        end
      end

      default: ;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      total_q     <= CNT_W'(1);
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
      walk_addr_q <= '0;
      walk_left_q <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      cur_valid_q <= cur_valid_d;
      cur_q       <= cur_d;
      walk_addr_q <= walk_addr_d;
      walk_left_q <= walk_left_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    qidx_q       <= qidx_d;
    chk_addr_q   <= chk_addr_d;
    res_status_q <= res_status_d;
    res_chosen_q <= res_chosen_d;
    res_prev_q   <= res_prev_d;
    res_sw_q     <= res_sw_d;
    res_qstate_q <= res_qstate_d;
    res_qvalid_q <= res_qvalid_d;
    res_recl_q   <= res_recl_d;
    out_status_q <= out_status_d;
    out_chosen_q <= out_chosen_d;
    out_prev_q   <= out_prev_d;
    out_sw_q     <= out_sw_d;
    out_rvalid_q <= out_rvalid_d;
    out_rtask_q  <= out_rtask_d;
    out_total_q  <= out_total_d;
    out_qstate_q <= out_qstate_d;
    out_qvalid_q <= out_qvalid_d;
    out_recl_q   <= out_recl_d;
  end

  // ---- ports ----
  assign in_stall_o        = state_q != SQ_IDLE;
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign chosen_task_o     = out_chosen_q;
  assign previous_task_o   = out_prev_q;
  assign switched_o        = out_sw_q;
  assign running_valid_o   = out_rvalid_q;
  assign running_task_o    = out_rtask_q;
  assign tasks_in_table_o  = out_total_q;
  assign queried_state_o   = out_qstate_q;
  assign query_valid_o     = out_qvalid_q;
  assign reclaimed_count_o = out_recl_q;

endmodule

// ===== verif/rrts_result_check.sv =====
// ---------------------------------------------------------------------------
// rrts_result_check: result predictor and comparator for the task scheduler
// Watches both channels, keeps its own copy of the task table, predicts one
// result per accepted request and compares it field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module rrts_result_check
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] func_i,
  input  logic [3:0] task_index_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] status_i,
  input  logic [3:0] chosen_task_i,
  input  logic [3:0] previous_task_i,
  input  logic       switched_i,
  input  logic       running_valid_i,
  input  logic [3:0] running_task_i,
  input  logic [4:0] tasks_in_table_i,
  input  logic [1:0] queried_state_i,
  input  logic       query_valid_i,
  input  logic [4:0] reclaimed_count_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    status_e    status;
    logic [3:0] chosen;
    logic [3:0] previous;
    logic       switched;
    logic       run_valid;
    logic [3:0] run_slot;
    logic [4:0] in_table;
    tstate_e    q_state;
    logic       q_valid;
    logic [4:0] reclaimed;
  } sched_result_t;

  // shadow of the task table
  tstate_e slot_state [MAX_TASKS];
  int      slot_total;
  bit      run_valid;
  int      run_slot;

  sched_result_t awaited_results [$];
  sched_result_t want, seen;
  int            results_seen;
  int            took_req, gave_res;

  function automatic void clear_table();
    for (int i = 0; i < MAX_TASKS; i++) slot_state[i] = TS_READY;
    slot_total = 1;
    run_valid  = 1'b0;
    run_slot   = 0;
  endfunction

  // first ready slot after cur, wrapping; slot_total when none
  function automatic int next_ready_after(int cur);
    int found, slot;
    found = slot_total;
    for (int k = slot_total; k >= 1; k--) begin
      slot = (cur + k) % slot_total;
      if (slot_state[slot] == TS_READY) found = slot;
    end
    return found;
  endfunction

  function automatic sched_result_t schedule_outcome(logic [2:0] op, logic [3:0] qidx);
    sched_result_t r;
    int            nx, prev, count;
    bit            cur_ok;
    r      = '0;
    prev   = 0;
    count  = 0;
    cur_ok = run_valid && (run_slot < slot_total);
    case (op)
      FN_INIT: begin
        slot_total   = 1;
        slot_state[0] = TS_READY;
        run_valid    = 1'b0;
        run_slot     = 0;
      end
      FN_CREATE: begin
        if (slot_total >= MAX_TASKS) begin
          r.status = STS_REFUSED;
        end else begin
          slot_state[slot_total] = TS_READY;
          r.chosen = 4'(slot_total);
          slot_total++;
        end
      end
      FN_YIELD: begin
        if (!cur_ok || slot_total < 2) begin
          r.status = STS_NOCHG;
        end else begin
          prev             = run_slot;
          slot_state[prev] = TS_READY;
          nx               = next_ready_after(prev);
          if (nx >= slot_total) nx = prev;
          run_slot       = nx;
          slot_state[nx] = TS_RUNNING;
          r.previous     = 4'(prev);
          r.chosen       = 4'(nx);
          r.switched     = (nx != prev);
        end
      end
      FN_EXIT: begin
        if (!cur_ok) begin
          r.status = STS_HALT;
        end else begin
          prev             = run_slot;
          r.previous       = 4'(prev);
          slot_state[prev] = TS_ZOMBIE;
          nx               = next_ready_after(prev);
          if (nx >= slot_total) begin
            run_valid = 1'b0;
            r.status  = STS_HALT;
          end else begin
            run_slot       = nx;
            slot_state[nx] = TS_RUNNING;
            r.chosen       = 4'(nx);
            r.switched     = 1'b1;
          end
        end
      end
      FN_START: begin
        nx = slot_total;
        for (int i = slot_total - 1; i >= 1; i--)
          if (slot_state[i] == TS_READY) nx = i;
        if (nx >= slot_total) begin
          r.status = STS_NOCHG;
        end else begin
          if (cur_ok) r.previous = 4'(run_slot);
          run_slot       = nx;
          run_valid      = 1'b1;
          slot_state[nx] = TS_RUNNING;
          r.chosen       = 4'(nx);
          r.switched     = 1'b1;
        end
      end
      FN_RECLAIM: begin
        for (int i = 0; i < slot_total; i++) begin
          if (slot_state[i] == TS_ZOMBIE) begin
            slot_state[i] = TS_EXITED;
            count++;
          end
        end
        r.reclaimed = 5'(count);
      end
      FN_QUERY: begin
        if (qidx < slot_total) begin
          r.q_valid = 1'b1;
          r.q_state = slot_state[qidx];
        end else begin
          r.status = STS_REFUSED;
        end
      end
      default: r.status = STS_REFUSED;
    endcase
    r.run_valid = run_valid;
    r.run_slot  = run_valid ? 4'(run_slot) : 4'd0;
    r.in_table  = 5'(slot_total);
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      fail_count_o++;
      $display("%0t: result %0d %s mismatch, expected %0d, got %0d",
               $time, results_seen, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      awaited_results.delete();
      results_seen = 0;
      pending_o   <= 0;
    end else begin
      took_req = in_valid_i && !in_stall_i;
      gave_res = out_valid_i && !out_stall_i;
      if (gave_res) begin
        seen = '{status_e'(status_i), chosen_task_i, previous_task_i, switched_i,
                 running_valid_i, running_task_i, tasks_in_table_i,
                 tstate_e'(queried_state_i), query_valid_i, reclaimed_count_i};
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no request waiting, expected none, got status %0d",
                   $time, status_i);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", int'(want.status), int'(seen.status));
          check_field("chosen_task", int'(want.chosen), int'(seen.chosen));
          check_field("previous_task", int'(want.previous), int'(seen.previous));
          check_field("switched", int'(want.switched), int'(seen.switched));
          check_field("running_valid", int'(want.run_valid), int'(seen.run_valid));
          check_field("running_task", int'(want.run_slot), int'(seen.run_slot));
          check_field("tasks_in_table", int'(want.in_table), int'(seen.in_table));
          check_field("queried_state", int'(want.q_state), int'(seen.q_state));
          check_field("query_valid", int'(want.q_valid), int'(seen.q_valid));
          check_field("reclaimed_count", int'(want.reclaimed), int'(seen.reclaimed));
        end
        results_seen++;
      end
      if (took_req) awaited_results.push_back(schedule_outcome(func_i, task_index_i));
      pending_o <= pending_o + took_req - gave_res;
    end
  end

endmodule

// ===== verif/round_robin_task_scheduler_tb.sv =====
// ---------------------------------------------------------------------------
// round_robin_task_scheduler_tb: top of the scheduler testbench
// Drives a directed run through the scheduler's corner cases, then random
// episodes of init, create, start and mixed operations under four idling
// regimes. Results are predicted and compared by the result checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module round_robin_task_scheduler_tb;
  import rrts_pkg::*;

  localparam int         MAX_TASKS       = 16;
  localparam int         PHASE_REQUESTS  = 215;    // floor on random requests per phase
  localparam int         HOLD_OFF_CYCLES = 300;    // long receiver hold-off
  localparam int         DRAIN_CYCLES    = 40;     // outlasts the worst table walk
  localparam logic [2:0] FN_UNDEFINED    = 3'd7;   // code with no operation

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] func_i;
  logic [3:0] task_index_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] status_o;
  logic [3:0] chosen_task_o;
  logic [3:0] previous_task_o;
  logic       switched_o;
  logic       running_valid_o;
  logic [3:0] running_task_o;
  logic [4:0] tasks_in_table_o;
  logic [1:0] queried_state_o;
  logic       query_valid_o;
  logic [4:0] reclaimed_count_o;

  int fail_count;
  int pending;          // requests taken whose result has not yet been taken
  int requests_sent;
  int gap_pct;          // chance per cycle that the sender stays idle
  int stall_pct;        // chance per cycle that the receiver stalls
  bit hold_off_pending; // asks the receiver for one long hold-off

  round_robin_task_scheduler #(
    .MAX_TASKS(MAX_TASKS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .task_index_i     (task_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .chosen_task_o    (chosen_task_o),
    .previous_task_o  (previous_task_o),
    .switched_o       (switched_o),
    .running_valid_o  (running_valid_o),
    .running_task_o   (running_task_o),
    .tasks_in_table_o (tasks_in_table_o),
    .queried_state_o  (queried_state_o),
    .query_valid_o    (query_valid_o),
    .reclaimed_count_o(reclaimed_count_o)
  );

  rrts_result_check #(
    .MAX_TASKS(MAX_TASKS)
  ) sched_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .func_i           (func_i),
    .task_index_i     (task_index_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .chosen_task_i    (chosen_task_o),
    .previous_task_i  (previous_task_o),
    .switched_i       (switched_o),
    .running_valid_i  (running_valid_o),
    .running_task_i   (running_task_o),
    .tasks_in_table_i (tasks_in_table_o),
    .queried_state_i  (queried_state_o),
    .query_valid_i    (query_valid_o),
    .reclaimed_count_i(reclaimed_count_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin
    #6_000_000;
    $display("round_robin_task_scheduler_tb NOT OK");
    $finish;
  end

  // Receiver: random stalls at stall_pct, plus one long hold-off on demand.
  // During the hold-off the sender keeps offering, so the output register
  // fills, the next request finishes behind it and the input stalls.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_pending = 1'b0;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one request, with random idle cycles first, and return at the
  // edge that takes it. Valid is only written once per edge, so a request
  // that follows straight on keeps valid high without a glitch.
  task automatic send_request(input logic [2:0] op, input logic [3:0] slot);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= op;
    task_index_i <= slot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stop offering and wait until every result has been taken.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mix for the body of an episode: mostly switching and queries.
  function automatic logic [2:0] pick_operation();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30)      pick_operation = FN_YIELD;
    else if (roll < 52) pick_operation = FN_QUERY;
    else if (roll < 64) pick_operation = FN_EXIT;
    else if (roll < 76) pick_operation = FN_CREATE;
    else if (roll < 85) pick_operation = FN_START;
    else if (roll < 93) pick_operation = FN_RECLAIM;
    else if (roll < 97) pick_operation = FN_INIT;
    else                pick_operation = FN_UNDEFINED;
  endfunction

  // A well-formed episode: (usually) init, a few creates, start, then a
  // random mix. Creates carry on without init now and then, so the table
  // fills up and create gets refused.
  task automatic run_episode(input bit fill_table);
    int creates;
    int ops;
    if (fill_table || $urandom_range(0, 3) != 0)
      send_request(FN_INIT, 4'($urandom_range(0, 15)));
    if (fill_table)                    creates = MAX_TASKS;  // last one refused
    else if ($urandom_range(0, 4) == 0) creates = $urandom_range(8, 17);
    else                               creates = $urandom_range(1, 5);
    repeat (creates) send_request(FN_CREATE, 4'($urandom_range(0, 15)));
    send_request(FN_START, 4'($urandom_range(0, 15)));
    ops = $urandom_range(8, 40);
    repeat (ops) send_request(pick_operation(), 4'($urandom_range(0, 15)));
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    func_i           <= FN_INIT;
    task_index_i     <= 4'd0;
    requests_sent    = 0;
    gap_pct          = 0;
    stall_pct        = 0;
    hold_off_pending = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: only the idle task exists after reset ---
    send_request(FN_QUERY, 4'd15);        // index past the table: refused
    send_request(FN_YIELD, 4'd0);         // nothing running: no change
    send_request(FN_EXIT, 4'd0);          // nothing running: halt
    send_request(FN_START, 4'd0);         // fewer than two tasks: no change
    send_request(FN_UNDEFINED, 4'd15);    // unknown operation: refused
    send_request(FN_CREATE, 4'd0);        // slot 1
    send_request(FN_CREATE, 4'd0);        // slot 2
    send_request(FN_START, 4'd0);         // runs 1
    send_request(FN_START, 4'd0);         // runs 2, slot 1 stays marked running
    send_request(FN_QUERY, 4'd1);
    send_request(FN_YIELD, 4'd0);         // 2 -> wraps round to idle 0
    send_request(FN_EXIT, 4'd0);          // 0 zombie, 2 picked up
    send_request(FN_EXIT, 4'd0);          // no ready task left: halt, none running
    send_request(FN_RECLAIM, 4'd0);       // two zombies go to exited
    send_request(FN_QUERY, 4'd2);
    send_request(FN_START, 4'd0);         // slots 1 and 2 not ready: no change
    send_request(FN_INIT, 4'd0);
    send_request(FN_CREATE, 4'd0);
    send_request(FN_START, 4'd0);         // runs 1
    send_request(FN_YIELD, 4'd0);         // hands over to idle 0
    send_request(FN_EXIT, 4'd0);          // idle exits, 1 runs again
    send_request(FN_YIELD, 4'd0);         // only itself ready: no switch
    wait_until_drained();

    // --- random phases, each with its own idling regime ---
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 49; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      // The sender goes on offering while the receiver holds off.
      if (phase == 1) hold_off_pending = 1'b1;
      requests_sent = 0;
      run_episode(1'b1);                  // full table and a refused create
      while (requests_sent < PHASE_REQUESTS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any code, any index
          repeat (20) send_request(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        end else begin
          run_episode(1'b0);
        end
      end
      // Pause the sender until every result is back.
      wait_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("round_robin_task_scheduler_tb OK");
    else
      $display("round_robin_task_scheduler_tb NOT OK");
    $finish;
  end

endmodule

// ===== round_robin_task_scheduler.f =====
design/rrts_pkg.sv
design/round_robin_task_scheduler.sv
verif/rrts_result_check.sv
verif/round_robin_task_scheduler_tb.sv
